@@ rtl/vpk_pkg.sv @@
// Package for the position/velocity Kalman filter.
// Holds the shared unit opcodes, request struct, state and register codes.
// No dependencies.
`default_nettype none

package vpk_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    OP_MUL_F,
    OP_MUL_24,
    OP_MUL_24F,
    OP_DIV
  } vpk_op_e;

  typedef struct packed {
    logic    start;
    vpk_op_e op;
  } vpk_req_t;

  typedef enum logic [1:0] {
    UNIT_IDLE,
    UNIT_MUL,
    UNIT_DIV,
    UNIT_FIN
  } vpk_ustate_e;

  typedef enum logic [2:0] {
    REG_STEP_TIME,
    REG_Q_POSITION,
    REG_Q_CROSS,
    REG_Q_VELOCITY,
    REG_R_MEASURE,
    REG_ACCEL_OFFSET,
    REG_ACCEL_GAIN,
    REG_SPEED_SCALE
  } vpk_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ACC,
    S_PPRED,
    S_VPRED,
    S_M3,
    S_M2,
    S_MT,
    S_SUMS,
    S_K0,
    S_K1,
    S_MEAS,
    S_PCOR,
    S_VCOR,
    S_C0,
    S_C1,
    S_C2,
    S_C3,
    S_OUT
  } vpk_state_e;

endpackage

`default_nettype wire

@@ rtl/vpk_unit.sv @@
// Shared arithmetic unit: 8-bit-per-cycle multiplier and restoring divider.
// Results are truncated toward zero and saturated to DATA_WIDTH. Uses vpk_pkg.
`default_nettype none

module vpk_unit import vpk_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned OPW = DATA_WIDTH + 2,
  localparam int unsigned SW  = ((DATA_WIDTH > 31) ? DATA_WIDTH : 31) + 1,
  localparam int unsigned BW  = (OPW > SW) ? OPW : SW
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire vpk_req_t                     req_i,
  input  wire logic signed [OPW-1:0]        a_i,
  input  wire logic        [BW-1:0]         b_i,
  output logic                              done_o,
  output logic signed [DATA_WIDTH-1:0]      res_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned CH  = (OPW + 7) / 8;
  localparam int unsigned MBW = CH * 8;
  localparam int unsigned PW  = OPW + MBW;
  localparam int unsigned NW  = W + FRAC_BITS;
  localparam int unsigned RW  = SW + 1;
  localparam int unsigned MW  = (PW > NW) ? PW : NW;
  localparam int unsigned NC  = (CH > NW) ? CH : NW;
  localparam int unsigned CW  = $clog2(NC + 1);

  vpk_ustate_e         st_q, st_d;
  vpk_op_e             op_q, op_d;
  logic                neg_q, neg_d;
  logic [OPW-1:0]      ma_q, ma_d;
  logic [MBW-1:0]      mb_q, mb_d;
  logic [PW-1:0]       acc_q, acc_d;
  logic [SW-1:0]       den_q, den_d;
  logic [RW-1:0]       rem_q, rem_d;
  logic [NW-1:0]       quo_q, quo_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [W-1:0]        res_q, res_d;
  logic                done_q, done_d;

  logic signed [OPW-1:0] b_s;
  logic [OPW-1:0]        a_mag, b_mag;
  logic [RW-1:0]         rem_sh;
  logic [MW-1:0]         mag;
  logic [MW-1:0]         lim;

  assign b_s   = signed'(b_i[OPW-1:0]);
  assign a_mag = a_i[OPW-1] ? OPW'(-a_i) : OPW'(a_i);
  assign b_mag = b_s[OPW-1] ? OPW'(-b_s) : OPW'(b_s);
  assign rem_sh = {rem_q[RW-2:0], quo_q[NW-1]};
  assign lim = MW'(1) << (W - 1);

  always_comb begin
    st_d   = st_q;
    op_d   = op_q;
    neg_d  = neg_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    acc_d  = acc_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    done_d = 1'b0;
    mag    = '0;
    unique case (st_q)
      UNIT_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          ma_d  = a_mag;
          mb_d  = MBW'(b_mag);
          acc_d = '0;
          den_d = b_i[SW-1:0];
          rem_d = '0;
          quo_d = {a_mag[W-1:0], {FRAC_BITS{1'b0}}};
          if (req_i.op == OP_DIV) begin
            neg_d = a_i[OPW-1];
            cnt_d = CW'(NW);
            st_d  = UNIT_DIV;
          end else begin
            neg_d = a_i[OPW-1] ^ b_s[OPW-1];
            cnt_d = CW'(CH);
            st_d  = UNIT_MUL;
          end
        end
      end
      UNIT_MUL: begin
        acc_d = (acc_q << 8) + PW'(ma_q * mb_q[MBW-1 -: 8]);
        mb_d  = mb_q << 8;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) st_d = UNIT_FIN;
      end
      UNIT_DIV: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = rem_sh - {1'b0, den_q};
          quo_d = {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[NW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) st_d = UNIT_FIN;
      end
      UNIT_FIN: begin
        case (op_q)
          OP_MUL_F:   mag = MW'(acc_q >> FRAC_BITS);
          OP_MUL_24:  mag = MW'(acc_q >> 24);
          OP_MUL_24F: mag = MW'(acc_q >> (24 - FRAC_BITS));
          default:    mag = MW'(quo_q);
        endcase
        if (!neg_q) begin
          res_d = (mag > lim - 1'b1) ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
        end else begin
          res_d = (mag > lim) ? {1'b1, {(W-1){1'b0}}} : W'(-mag[W-1:0]);
        end
        done_d = 1'b1;
        st_d   = UNIT_IDLE;
      end
      default: st_d = UNIT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= UNIT_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = signed'(res_q);

endmodule

`default_nettype wire

@@ rtl/velocity_position_kalman.sv @@
// Two-state position/velocity Kalman filter, top level with step sequencer.
// Depends on vpk_pkg and vpk_unit.
//
// One beat in gives one beat out. A step runs thirteen multiplies and two
// divides on the single shared unit in vpk_unit, one after another (the
// divides are skipped when r_measure plus the velocity variance is not
// positive). The input stalls for the whole step; the result waits in an
// output register.
`default_nettype none

module velocity_position_kalman import vpk_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_addr_i,
  input  wire logic [30:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [24:0] accel_along_i,
  input  wire logic signed [15:0] wheel_left_i,
  input  wire logic signed [15:0] wheel_right_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      position_out_o,
  output logic signed [31:0]      velocity_out_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned OPW = W + 2;
  localparam int unsigned SW  = ((W > 31) ? W : 31) + 1;
  localparam int unsigned BW  = (OPW > SW) ? OPW : SW;
  localparam int unsigned XW  = ((W > 32) ? W : 32) + 4;
  localparam int unsigned YW  = (W > 32) ? W : 32;
  localparam logic signed [XW-1:0] BIG_X   = signed'(XW'(1000) << FRAC_BITS);
  localparam logic signed [XW-1:0] SMALL_X = signed'(XW'(100) << FRAC_BITS);

  function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = signed'(XW'({1'b0, {(W-1){1'b1}}}));
    lo = -hi - 1;
    if (v > hi) return hi[W-1:0];
    else if (v < lo) return lo[W-1:0];
    else return v[W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [W-1:0] v);
    logic signed [YW-1:0] y;
    logic signed [YW-1:0] hi;
    logic signed [YW-1:0] lo;
    y  = YW'(v);
    hi = signed'(YW'(32'h7fff_ffff));
    lo = -hi - 1;
    if (y > hi) return 32'sh7fff_ffff;
    else if (y < lo) return 32'sh8000_0000;
    else return y[31:0];
  endfunction

  function automatic logic signed [XW-1:0] xs(input logic signed [W-1:0] v);
    return XW'(v);
  endfunction

  logic [16:0]        step_time_q;
  logic [30:0]        q_position_q, q_cross_q, q_velocity_q, r_measure_q;
  logic signed [23:0] accel_offset_q;
  logic [23:0]        accel_gain_q, speed_scale_q;

  vpk_state_e         state_q, state_d;
  logic               issued_q, issued_d;
  logic signed [W-1:0] pos_q, pos_d, vel_q, vel_d;
  logic signed [W-1:0] cov0_q, cov0_d, cov1_q, cov1_d, cov2_q, cov2_d, cov3_q, cov3_d;
  logic signed [W-1:0] acc_q, acc_d, m3_q, m3_d, m2_q, m2_d, mt_q, mt_d, t_q, t_d;
  logic signed [W-1:0] p0_q, p0_d, p1_q, p1_d, p2_q, p2_d, p3_q, p3_d;
  logic signed [W-1:0] k0_q, k0_d, k1_q, k1_d, err_q, err_d;
  logic signed [XW-1:0] s_q, s_d;
  logic signed [24:0] along_q;
  logic signed [15:0] wl_q, wr_q;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] pos_out_q, pos_out_d, vel_out_q, vel_out_d;

  vpk_req_t               req;
  logic signed [OPW-1:0]  op_a;
  logic [BW-1:0]          op_b;
  logic                   u_done;
  logic signed [W-1:0]    u_res;
  logic signed [OPW-1:0]  om;
  logic                   in_take;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign om    = signed'(OPW'(1) << FRAC_BITS) - OPW'(k1_q);

  vpk_unit #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (u_done),
    .res_o  (u_res)
  );

  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    pos_d = pos_q;   vel_d = vel_q;
    cov0_d = cov0_q; cov1_d = cov1_q; cov2_d = cov2_q; cov3_d = cov3_q;
    acc_d = acc_q;   m3_d = m3_q;   m2_d = m2_q;   mt_d = mt_q;   t_d = t_q;
    p0_d = p0_q;     p1_d = p1_q;   p2_d = p2_q;   p3_d = p3_q;
    k0_d = k0_q;     k1_d = k1_q;   err_d = err_q; s_d = s_q;
    out_valid_d = out_valid_q && out_stall_i;
    pos_out_d   = pos_out_q;
    vel_out_d   = vel_out_q;
    req.start   = 1'b0;
    req.op      = OP_MUL_F;
    op_a        = '0;
    op_b        = '0;

    unique case (state_q)
      S_ACC: begin
        op_a = OPW'(accel_offset_q) - OPW'(along_q);
        op_b = BW'(accel_gain_q);
        req.op = OP_MUL_24;
      end
      S_PPRED: begin op_a = OPW'(vel_q);  op_b = BW'(step_time_q); end
      S_VPRED: begin op_a = OPW'(acc_q);  op_b = BW'(step_time_q); end
      S_M3:    begin op_a = OPW'(step_time_q); op_b = BW'(cov3_q); end
      S_M2:    begin op_a = OPW'(step_time_q); op_b = BW'(cov2_q); end
      S_MT:    begin op_a = OPW'(step_time_q); op_b = BW'(t_q); end
      S_K0:    begin op_a = OPW'(p1_q); op_b = BW'(s_q[SW-1:0]); req.op = OP_DIV; end
      S_K1:    begin op_a = OPW'(p3_q); op_b = BW'(s_q[SW-1:0]); req.op = OP_DIV; end
      S_MEAS: begin
        op_a = OPW'(wl_q) - OPW'(wr_q);
        op_b = BW'(speed_scale_q);
        req.op = OP_MUL_24F;
      end
      S_PCOR:  begin op_a = OPW'(k0_q); op_b = BW'(err_q); end
      S_VCOR:  begin op_a = OPW'(k1_q); op_b = BW'(err_q); end
      S_C0:    begin op_a = OPW'(k0_q); op_b = BW'(p2_q); end
      S_C1:    begin op_a = OPW'(k0_q); op_b = BW'(p3_q); end
      S_C2:    begin op_a = OPW'(p2_q); op_b = BW'(om); end
      S_C3:    begin op_a = OPW'(p3_q); op_b = BW'(om); end
      default: ;
    endcase

    unique case (state_q)
      S_IDLE: begin
        if (in_take) state_d = S_ACC;
      end
      S_SUMS: begin
        p0_d = sat_x(xs(cov0_q) + xs(m2_q) + xs(mt_q) + signed'(XW'(q_position_q)));
        p1_d = sat_x(xs(cov1_q) + xs(m3_q) + signed'(XW'(q_cross_q)));
        p2_d = sat_x(xs(cov2_q) + xs(m3_q) + signed'(XW'(q_cross_q)));
        p3_d = sat_x(xs(cov3_q) + signed'(XW'(q_velocity_q)));
        state_d = S_K0;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          pos_out_d   = sat32(pos_q);
          vel_out_d   = sat32(vel_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        if (!issued_q) begin
          if (state_q == S_K0 && s_q <= 0) begin
            k0_d    = '0;
            state_d = S_K1;
          end else if (state_q == S_K1 && s_q <= 0) begin
            k1_d    = '0;
            state_d = S_MEAS;
          end else begin
            req.start = 1'b1;
            issued_d  = 1'b1;
          end
        end else if (u_done) begin
          issued_d = 1'b0;
          case (state_q)
            S_ACC:   begin acc_d = u_res; state_d = S_PPRED; end
            S_PPRED: begin pos_d = sat_x(xs(pos_q) + xs(u_res)); state_d = S_VPRED; end
            S_VPRED: begin vel_d = sat_x(xs(vel_q) + xs(u_res)); state_d = S_M3; end
            S_M3: begin
              m3_d = u_res;
              t_d  = sat_x(xs(cov1_q) + xs(u_res));
              state_d = S_M2;
            end
            S_M2:    begin m2_d = u_res; state_d = S_MT; end
            S_MT: begin
              mt_d = u_res;
              state_d = S_SUMS;
            end
            S_K0:    begin k0_d = u_res; state_d = S_K1; end
            S_K1:    begin k1_d = u_res; state_d = S_MEAS; end
            S_MEAS:  begin err_d = sat_x(xs(u_res) - xs(vel_q)); state_d = S_PCOR; end
            S_PCOR:  begin pos_d = sat_x(xs(pos_q) + xs(u_res)); state_d = S_VCOR; end
            S_VCOR:  begin vel_d = sat_x(xs(vel_q) + xs(u_res)); state_d = S_C0; end
            S_C0:    begin cov0_d = sat_x(xs(p0_q) - xs(u_res)); state_d = S_C1; end
            S_C1:    begin cov1_d = sat_x(xs(p1_q) - xs(u_res)); state_d = S_C2; end
            S_C2:    begin cov2_d = u_res; state_d = S_C3; end
            S_C3:    begin cov3_d = u_res; state_d = S_OUT; end
            default: state_d = S_IDLE;
          endcase
        end
      end
    endcase
    if (state_q == S_SUMS) s_d = xs(p3_d) + signed'(XW'(r_measure_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      issued_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      step_time_q    <= 17'd655;
      q_position_q   <= 31'd19661;
      q_cross_q      <= 31'd66;
      q_velocity_q   <= 31'd13107;
      r_measure_q    <= 31'd6554;
      accel_offset_q <= 24'sd1278;
      accel_gain_q   <= 24'd4412;
      speed_scale_q  <= 24'd36219;
      pos_q          <= '0;
      vel_q          <= '0;
      cov0_q         <= sat_x(BIG_X);
      cov1_q         <= sat_x(SMALL_X);
      cov2_q         <= sat_x(SMALL_X);
      cov3_q         <= sat_x(BIG_X);
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      pos_q <= pos_d;   vel_q <= vel_d;
      cov0_q <= cov0_d; cov1_q <= cov1_d; cov2_q <= cov2_d; cov3_q <= cov3_d;
      if (cfg_we_i) begin
        unique case (vpk_reg_e'(cfg_addr_i))
          REG_STEP_TIME:    step_time_q    <= cfg_data_i[16:0];
          REG_Q_POSITION:   q_position_q   <= cfg_data_i;
          REG_Q_CROSS:      q_cross_q      <= cfg_data_i;
          REG_Q_VELOCITY:   q_velocity_q   <= cfg_data_i;
          REG_R_MEASURE:    r_measure_q    <= cfg_data_i;
          REG_ACCEL_OFFSET: accel_offset_q <= signed'(cfg_data_i[23:0]);
          REG_ACCEL_GAIN:   accel_gain_q   <= cfg_data_i[23:0];
          REG_SPEED_SCALE:  speed_scale_q  <= cfg_data_i[23:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      along_q <= accel_along_i;
      wl_q    <= wheel_left_i;
      wr_q    <= wheel_right_i;
    end
    acc_q <= acc_d; m3_q <= m3_d; m2_q <= m2_d; mt_q <= mt_d; t_q <= t_d;
    p0_q <= p0_d;   p1_q <= p1_d; p2_q <= p2_d; p3_q <= p3_d;
    k0_q <= k0_d;   k1_q <= k1_d; err_q <= err_d; s_q <= s_d;
    pos_out_q <= pos_out_d;
    vel_out_q <= vel_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign position_out_o = pos_out_q;
  assign velocity_out_o = vel_out_q;

endmodule

`default_nettype wire

@@ test/velocity_position_kalman_test.sv @@
// Self-checking testbench for velocity_position_kalman: random and directed steps
// against a built-in fixed-point predictor. Both handshakes idle at random.
// Depends on vpk_pkg and the velocity_position_kalman RTL.
module velocity_position_kalman_test import vpk_pkg::*;;

  typedef struct {
    logic signed [24:0] accel;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } sample_t;

  typedef struct {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } estimate_t;

  localparam int unsigned FRAC = 16;
  localparam int unsigned STALL_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [24:0] accel_along_i = '0;
  logic signed [15:0] wheel_left_i = '0;
  logic signed [15:0] wheel_right_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] position_out_o;
  logic signed [31:0] velocity_out_o;

  velocity_position_kalman dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and register copies
  longint step_dt, q_pos, q_crs, q_vel, r_meas, acc_bias, acc_gain, spd_scale;
  longint pos_est, vel_est;
  longint cov [4];

  sample_t   pending_samples[$];
  estimate_t expected_estimates[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_len = 0;
  bit calm = 0;
  logic in_taken = 1'b0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_shift(longint a, longint b, int unsigned sh);
    longint p;
    p = a * b;
    return sat32(p < 0 ? -((-p) >>> sh) : (p >>> sh));
  endfunction

  function automatic longint div_frac(longint num, longint den);
    longint q;
    q = ((num < 0 ? -num : num) << FRAC) / den;
    return sat32(num < 0 ? -q : q);
  endfunction

  function automatic void reset_filter();
    step_dt = 655; q_pos = 19661; q_crs = 66; q_vel = 13107; r_meas = 6554;
    acc_bias = 1278; acc_gain = 4412; spd_scale = 36219;
    pos_est = 0; vel_est = 0;
    cov[0] = 1000 << FRAC; cov[1] = 100 << FRAC;
    cov[2] = 100 << FRAC;  cov[3] = 1000 << FRAC;
  endfunction

  function automatic estimate_t kalman_step(sample_t s);
    longint acc, t, p0, p1, p2, p3, sv, k0, k1, meas, err, om;
    estimate_t e;
    k0 = 0;
    k1 = 0;
    acc = mul_shift(acc_bias - longint'(s.accel), acc_gain, 24);
    pos_est = sat32(pos_est + mul_shift(vel_est, step_dt, FRAC));
    vel_est = sat32(vel_est + mul_shift(acc, step_dt, FRAC));
    t  = sat32(cov[1] + mul_shift(step_dt, cov[3], FRAC));
    p0 = sat32(cov[0] + mul_shift(step_dt, cov[2], FRAC) + mul_shift(step_dt, t, FRAC) + q_pos);
    p1 = sat32(cov[1] + mul_shift(step_dt, cov[3], FRAC) + q_crs);
    p2 = sat32(cov[2] + mul_shift(step_dt, cov[3], FRAC) + q_crs);
    p3 = sat32(cov[3] + q_vel);
    sv = p3 + r_meas;
    if (sv > 0) begin
      k0 = div_frac(p1, sv);
      k1 = div_frac(p3, sv);
    end
    meas = mul_shift(longint'(s.left) - longint'(s.right), spd_scale, 24 - FRAC);
    err = sat32(meas - vel_est);
    pos_est = sat32(pos_est + mul_shift(k0, err, FRAC));
    vel_est = sat32(vel_est + mul_shift(k1, err, FRAC));
    om = (longint'(1) << FRAC) - k1;
    cov[0] = sat32(p0 - mul_shift(k0, p2, FRAC));
    cov[1] = sat32(p1 - mul_shift(k0, p3, FRAC));
    cov[2] = mul_shift(p2, om, FRAC);
    cov[3] = mul_shift(p3, om, FRAC);
    e.position = pos_est[31:0];
    e.velocity = vel_est[31:0];
    return e;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", field, $signed(got), $signed(want));
    errors++;
  endtask

  task automatic write_reg(vpk_reg_e idx, logic [30:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_STEP_TIME:    step_dt = value[16:0];
      REG_Q_POSITION:   q_pos = value;
      REG_Q_CROSS:      q_crs = value;
      REG_Q_VELOCITY:   q_vel = value;
      REG_R_MEASURE:    r_meas = value;
      REG_ACCEL_OFFSET: acc_bias = longint'($signed(value[23:0]));
      REG_ACCEL_GAIN:   acc_gain = value[23:0];
      default:          spd_scale = value[23:0];
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || expected_estimates.size() != 0 || in_valid_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_sample(logic signed [24:0] a, logic signed [15:0] l,
                             logic signed [15:0] r);
    sample_t s;
    s.accel = a;
    s.left = l;
    s.right = r;
    pending_samples.push_back(s);
  endtask

  task automatic push_random(int n);
    sample_t s;
    repeat (n) begin
      s.accel = 25'($urandom());
      s.left = 16'($urandom());
      s.right = 16'($urandom());
      if ($urandom_range(0, 2) == 0) begin
        s.accel = 25'($signed($urandom_range(0, 262143)) - 131072);
        s.right = 16'(s.left + $signed($urandom_range(0, 200)) - 100);
      end
      pending_samples.push_back(s);
    end
  endtask

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    if (out_valid_o && !out_stall_i) begin
      if (expected_estimates.size() == 0) begin
        $display("unexpected result beat: position %0d velocity %0d",
                 position_out_o, velocity_out_o);
        errors++;
      end else begin
        estimate_t e;
        e = expected_estimates.pop_front();
        if (position_out_o !== e.position) report_mismatch("position", position_out_o, e.position);
        if (velocity_out_o !== e.velocity) report_mismatch("velocity", velocity_out_o, e.velocity);
      end
    end
    if (in_valid_i && !in_stall_o)
      expected_estimates.push_back(kalman_step('{accel_along_i, wheel_left_i, wheel_right_i}));
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("velocity_position_kalman_test: done, errors");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold the beat
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_samples.size() > 0) begin
        sample_t s;
        s = pending_samples.pop_front();
        accel_along_i <= s.accel;
        wheel_left_i <= s.left;
        wheel_right_i <= s.right;
        in_valid_i <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        stall_len <= stall_len - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_len <= pick_gap();
      end
    end
  end

  initial begin
    reset_filter();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_sample(25'sh0, 16'sh0, 16'sh0);
    push_sample(25'sh0FFFFFF, 16'sh7FFF, -16'sh8000);
    push_sample(-25'sh1000000, -16'sh8000, 16'sh7FFF);
    push_sample(25'sh0FFFFFF, 16'sh7FFF, 16'sh7FFF);
    push_sample(-25'sh1000000, -16'sh8000, -16'sh8000);
    push_sample(25'sh1, 16'sh1, -16'sh1);
    push_sample(-25'sh1, -16'sh1, 16'sh1);
    push_random(8);
    wait_idle();

    // zero measurement and velocity process noise drive the velocity variance to zero, then no correction
    write_reg(REG_R_MEASURE, 31'd0);
    write_reg(REG_Q_VELOCITY, 31'd0);
    push_random(5);
    wait_idle();

    write_reg(REG_STEP_TIME, 31'h1FFFF);
    write_reg(REG_Q_POSITION, 31'h7FFFFFFF);
    write_reg(REG_Q_CROSS, 31'h7FFFFFFF);
    write_reg(REG_Q_VELOCITY, 31'h7FFFFFFF);
    write_reg(REG_R_MEASURE, 31'h7FFFFFFF);
    write_reg(REG_ACCEL_OFFSET, 31'h7FFFFFFF);
    write_reg(REG_ACCEL_GAIN, 31'h7FFFFFFF);
    write_reg(REG_SPEED_SCALE, 31'h7FFFFFFF);
    push_sample(-25'sh1000000, 16'sh7FFF, -16'sh8000);
    push_random(5);
    wait_idle();

    write_reg(REG_STEP_TIME, 31'd0);
    write_reg(REG_Q_POSITION, 31'd0);
    write_reg(REG_Q_CROSS, 31'd0);
    write_reg(REG_Q_VELOCITY, 31'd0);
    write_reg(REG_R_MEASURE, 31'd1);
    write_reg(REG_ACCEL_OFFSET, 31'h00800000);
    write_reg(REG_ACCEL_GAIN, 31'd0);
    write_reg(REG_SPEED_SCALE, 31'd0);
    push_random(5);
    wait_idle();

    for (int ph = 0; ph < 11; ph++) begin
      calm = (ph % 4 == 3);
      write_reg(REG_STEP_TIME,
                31'($urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 4000)));
      write_reg(REG_Q_POSITION,
                31'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 100000)));
      write_reg(REG_Q_CROSS,
                31'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1000)));
      write_reg(REG_Q_VELOCITY,
                31'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 100000)));
      write_reg(REG_R_MEASURE,
                31'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 100000)));
      write_reg(REG_ACCEL_OFFSET, 31'($urandom()));
      write_reg(REG_ACCEL_GAIN, 31'($urandom()));
      write_reg(REG_SPEED_SCALE, 31'($urandom()));
      push_random(140);
      wait_idle();
    end

    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("velocity_position_kalman_test: done, clean");
    end else begin
      $display("velocity_position_kalman_test: done, errors");
    end
    $finish;
  end
endmodule
